>>> hdl/ft12_frame_receiver_defines.svh
// ============================================================================
// ft12_frame_receiver_defines.svh
// Assertion macros shared by the FT1.2 receiver checker.
// ============================================================================
`ifndef FT12_FRAME_RECEIVER_DEFINES_SVH
`define FT12_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FT12_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ft12 check failed");

// Next-cycle implication, disabled in reset.
`define FT12_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ft12 check failed");

`endif

>>> hdl/ft12_pkg.sv
// ============================================================================
// ft12_pkg
// Types and constants of the FT1.2 frame receiver.
// ============================================================================
`default_nettype none

package ft12_pkg;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_ABORT = 2'd1;
    localparam logic [1:0] ST_SYNC  = 2'd2;

    // frame kinds
    localparam logic [1:0] KIND_VAR    = 2'd0;
    localparam logic [1:0] KIND_FIXED  = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;

    // start bytes
    localparam logic [7:0] START_VAR    = 8'h68;
    localparam logic [7:0] START_FIXED  = 8'h10;
    localparam logic [7:0] START_SINGLE = 8'hE5;

    // bytes after the length byte beyond L, and fixed-frame base length
    localparam logic [8:0] VAR_EXTRA   = 9'd4;
    localparam logic [8:0] FIXED_EXTRA = 9'd3;

    // configuration register indexes
    localparam logic REG_ADDR_LEN  = 1'b0;
    localparam logic REG_GAP_LIMIT = 1'b1;

    localparam logic [1:0]  ADDR_LEN_RESET  = 2'd1;
    localparam logic [15:0] GAP_LIMIT_RESET = 16'd300;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_DISCARD
    } phase_t;

    typedef struct packed {
        logic [1:0]  address_length;
        logic [15:0] char_gap_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] frame_kind;
        logic [7:0] byte_value;
        logic [8:0] byte_index;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/ft12_rx_core.sv
// ============================================================================
// ft12_rx_core
// Frame delimiter state machine: one transaction in, zero or one result out.
// ============================================================================
`default_nettype none

module ft12_rx_core (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_fire,
    input  wire                   in_op,
    input  wire  [7:0]            in_byte,
    input  ft12_pkg::cfg_t        cfg,
    output logic                  res_valid,
    output ft12_pkg::result_t     res
);

    ft12_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       kind_reg, kind_next;
    logic [8:0]       left_reg, left_next;
    logic [8:0]       pos_reg, pos_next;
    logic [15:0]      gap_reg, gap_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ft12_pkg::PH_HUNT;
            kind_reg  <= ft12_pkg::KIND_VAR;
            left_reg  <= '0;
            pos_reg   <= '0;
            gap_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            gap_reg   <= gap_next;
        end
    end

    always_comb begin
        logic [8:0] left_dec;
        left_dec   = left_reg - 9'd1;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        gap_next   = gap_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (in_fire) begin
            if (in_op == ft12_pkg::OP_TICK) begin
                if (phase_reg != ft12_pkg::PH_HUNT) begin
                    if (gap_reg >= cfg.char_gap_limit) begin
                        gap_next = '0;
                        case (phase_reg)
                            ft12_pkg::PH_LEN: begin
                                phase_next     = ft12_pkg::PH_DISCARD;
                                res_valid      = 1'b1;
                                res.status     = ft12_pkg::ST_SYNC;
                                res.frame_kind = ft12_pkg::KIND_VAR;
                            end
                            ft12_pkg::PH_BODY: begin
                                phase_next     = ft12_pkg::PH_HUNT;
                                res_valid      = 1'b1;
                                res.status     = ft12_pkg::ST_ABORT;
                                res.frame_kind = kind_reg;
                                res.byte_index = pos_reg;
                            end
                            default: begin
                                phase_next = ft12_pkg::PH_HUNT;
                            end
                        endcase
                    end else begin
                        gap_next = gap_reg + 16'd1;
                    end
                end
            end else begin
                gap_next = '0;
                case (phase_reg)
                    ft12_pkg::PH_HUNT: begin
                        res_valid      = 1'b1;
                        res.byte_value = in_byte;
                        if (in_byte == ft12_pkg::START_VAR) begin
                            kind_next      = ft12_pkg::KIND_VAR;
                            phase_next     = ft12_pkg::PH_LEN;
                            pos_next       = 9'd1;
                            res.status     = ft12_pkg::ST_BYTE;
                            res.frame_kind = ft12_pkg::KIND_VAR;
                        end else if (in_byte == ft12_pkg::START_FIXED) begin
                            kind_next      = ft12_pkg::KIND_FIXED;
                            phase_next     = ft12_pkg::PH_BODY;
                            left_next      = ft12_pkg::FIXED_EXTRA
                                             + {7'd0, cfg.address_length};
                            pos_next       = 9'd1;
                            res.status     = ft12_pkg::ST_BYTE;
                            res.frame_kind = ft12_pkg::KIND_FIXED;
                        end else if (in_byte == ft12_pkg::START_SINGLE) begin
                            kind_next      = ft12_pkg::KIND_SINGLE;
                            res.status     = ft12_pkg::ST_BYTE;
                            res.frame_kind = ft12_pkg::KIND_SINGLE;
                            res.last       = 1'b1;
                        end else begin
                            phase_next     = ft12_pkg::PH_DISCARD;
                            res.status     = ft12_pkg::ST_SYNC;
                            res.frame_kind = ft12_pkg::KIND_VAR;
                        end
                    end
                    ft12_pkg::PH_LEN: begin
                        left_next      = {1'b0, in_byte} + ft12_pkg::VAR_EXTRA;
                        pos_next       = 9'd2;
                        phase_next     = ft12_pkg::PH_BODY;
                        res_valid      = 1'b1;
                        res.status     = ft12_pkg::ST_BYTE;
                        res.frame_kind = ft12_pkg::KIND_VAR;
                        res.byte_value = in_byte;
                        res.byte_index = 9'd1;
                    end
                    ft12_pkg::PH_BODY: begin
                        left_next      = left_dec;
                        pos_next       = pos_reg + 9'd1;
                        if (left_dec == '0) begin
                            phase_next = ft12_pkg::PH_HUNT;
                        end
                        res_valid      = 1'b1;
                        res.status     = ft12_pkg::ST_BYTE;
                        res.frame_kind = kind_reg;
                        res.byte_value = in_byte;
                        res.byte_index = pos_reg;
                        res.last       = (left_dec == '0);
                    end
                    default: begin
                        // discarding: byte only restarts the gap timer
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ft12_out_buf.sv
// ============================================================================
// ft12_out_buf
// Output register with one skid entry between core and result channel.
// ============================================================================
`default_nettype none

module ft12_out_buf (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    input  ft12_pkg::result_t     in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    output ft12_pkg::result_t     out_data,
    input  wire                   out_ready
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    ft12_pkg::result_t main_reg;
    ft12_pkg::result_t skid_reg;
    logic              main_take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign main_take = !main_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_take) begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // in_valid is only raised while the skid entry is free
    always_ff @(posedge aclk) begin
        if (main_take) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (in_valid) begin
            skid_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ft12_frame_receiver.sv
// Each result is registered into the output register, or into the skid entry on a stall.
// Throughput: one input transaction per cycle; s_ready drops only when the one-entry
//   skid buffer is full, i.e. the result side has stalled with two results pending.
// Ticks and discarded bytes yield no result but are held off too while s_ready is low.
// Reset: synchronous, active-low aresetn; state returns to hunting, buffers empty,
//   address_length = 1 and char_gap_limit = 300.
// ============================================================================
// ft12_frame_receiver
// FT1.2 frame delimiter: splits a received UART byte stream, paced by
// millisecond ticks, into variable, fixed and single-character frames.
// ============================================================================
`default_nettype none

module ft12_frame_receiver (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration write port
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_wdata,
    // input channel: received bytes and ticks
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_op,
    input  wire  [7:0]  s_rx_byte,
    // result channel: frame bytes, aborts and sync errors
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_frame_kind,
    output logic [7:0]  m_byte_value,
    output logic [8:0]  m_byte_index,
    output logic        m_last
);

    ft12_pkg::cfg_t    cfg_reg;
    ft12_pkg::result_t core_res;
    ft12_pkg::result_t out_res;
    logic              core_res_valid;
    logic              in_fire;

    // Configuration registers. Writes are only expected while the block is idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.address_length <= ft12_pkg::ADDR_LEN_RESET;
            cfg_reg.char_gap_limit <= ft12_pkg::GAP_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ft12_pkg::REG_ADDR_LEN:  cfg_reg.address_length <= cfg_wdata[1:0];
                ft12_pkg::REG_GAP_LIMIT: cfg_reg.char_gap_limit <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A transaction is taken whenever the skid entry is free, so the state
    // machine advances exactly once per accepted byte or tick.
    assign in_fire = s_valid && s_ready;

    ft12_rx_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_op     (s_op),
        .in_byte   (s_rx_byte),
        .cfg       (cfg_reg),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    // Output register plus skid entry: keeps input flowing while a result
    // waits on m_ready.
    ft12_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (core_res_valid),
        .in_data   (core_res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_res),
        .out_ready (m_ready)
    );

    assign m_status     = out_res.status;
    assign m_frame_kind = out_res.frame_kind;
    assign m_byte_value = out_res.byte_value;
    assign m_byte_index = out_res.byte_index;
    assign m_last       = out_res.last;

endmodule

`default_nettype wire

>>> hdl/ft12_frame_receiver_checker.sv
// ============================================================================
// ft12_frame_receiver_checker
// Port-level checks on the FT1.2 receiver, bound to the top level.
// ============================================================================
`default_nettype none
`include "ft12_frame_receiver_defines.svh"

module ft12_frame_receiver_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        cfg_wr_en,
    input wire        cfg_index,
    input wire [15:0] cfg_wdata,
    input wire        s_valid,
    input wire        s_ready,
    input wire        s_op,
    input wire [7:0]  s_rx_byte,
    input wire        m_valid,
    input wire        m_ready,
    input wire [1:0]  m_status,
    input wire [1:0]  m_frame_kind,
    input wire [7:0]  m_byte_value,
    input wire [8:0]  m_byte_index,
    input wire        m_last
);

    // stalled result holds its payload
    `FT12_ASSERT_NXT(a_res_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable({m_status, m_frame_kind, m_byte_value, m_byte_index, m_last}))

    // input backpressure only follows a stalled result transaction
    `FT12_ASSERT_IMP(a_ready_cause, aclk, aresetn, !s_ready,
        $past(m_valid && !m_ready))

    // only frame bytes can close a frame
    `FT12_ASSERT_IMP(a_last_byte, aclk, aresetn, m_valid && m_last,
        m_status == ft12_pkg::ST_BYTE)

    // sync errors carry no frame position
    `FT12_ASSERT_IMP(a_sync_fields, aclk, aresetn, m_valid && m_status == ft12_pkg::ST_SYNC,
        m_byte_index == 9'd0 && m_frame_kind == ft12_pkg::KIND_VAR)

endmodule

bind ft12_frame_receiver ft12_frame_receiver_checker u_checker (.*);

`default_nettype wire
